[rtl/tcw_pkg.sv]
package tcw_pkg;

  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] BYTE_DC1     = 8'h11;
  localparam logic [7:0] SEL_COLOR    = 8'h01;
  localparam logic [7:0] SEL_CLEAR    = 8'h02;
  localparam logic [7:0] PEN_RESET    = 8'h07;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    K_READ,
    K_NEWLINE,
    K_DC1,
    K_SEL_COLOR,
    K_SEL_CLEAR,
    K_OTHER
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [10:0] read_index;
  } item_t;

endpackage

[rtl/text_console_writer.sv]
// a put is queued in the front and taken by the back sequencer in S_IDLE,
// which writes any cell and registers the result; a read goes on to S_READ
// for the registered store output, a scroll through S_SCROLL and S_DRAIN,
// a clear escape through a clearing pass; the back sequencer waits for each
// result to be taken before it starts the next request; reset: synchronous;
// a clearing pass then holds full high while the screen store is zeroed
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  input  logic [10:0] read_index,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  cursor_column,
  output logic [4:0]  cursor_row,
  output logic [7:0]  read_character,
  output logic [7:0]  read_color
);

  localparam int CELLS = COLUMNS * (ROWS - 1);
  localparam int AW    = $clog2(CELLS);

  logic           hold;
  logic           q_valid;
  logic           q_pop;
  tcw_pkg::item_t q_item;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [15:0]    ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [15:0]    ram_rdata;
  logic           res_valid;

  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .data_byte  (data_byte),
    .read_index (read_index),
    .hold       (hold),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .hold           (hold),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .res_valid      (res_valid),
    .res_pop        (pop),
    .cursor_column  (cursor_column),
    .cursor_row     (cursor_row),
    .read_character (read_character),
    .read_color     (read_color)
  );

  tcw_ram #(
    .W (16),
    .D (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign empty = !res_valid;

endmodule

[rtl/tcw_ram.sv]
module tcw_ram #(
  parameter int W = 16,
  parameter int D = 1920
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tcw_front.sv]
module tcw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              opcode,
  input  logic [7:0]        data_byte,
  input  logic [10:0]       read_index,
  input  logic              hold,
  output logic              q_valid,
  output tcw_pkg::item_t    q_item,
  input  logic              q_pop
);

  tcw_pkg::item_t entry [2];
  logic           wp;
  logic           rp;
  logic [1:0]     count;
  tcw_pkg::item_t cls;
  logic           do_push;

  always_comb begin
    cls.data_byte  = data_byte;
    cls.read_index = read_index;
    if (opcode == tcw_pkg::OP_READ) begin
      cls.kind = tcw_pkg::K_READ;
    end else begin
      case (data_byte)
        tcw_pkg::BYTE_NEWLINE: cls.kind = tcw_pkg::K_NEWLINE;
        tcw_pkg::BYTE_DC1:     cls.kind = tcw_pkg::K_DC1;
        tcw_pkg::SEL_COLOR:    cls.kind = tcw_pkg::K_SEL_COLOR;
        tcw_pkg::SEL_CLEAR:    cls.kind = tcw_pkg::K_SEL_CLEAR;
        default:               cls.kind = tcw_pkg::K_OTHER;
      endcase
    end
  end

  assign full    = hold || (count == 2'd2);
  assign do_push = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item  = entry[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        entry[wp] <= cls;
        wp        <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(do_push) - 2'(q_pop);
    end
  end

endmodule

[rtl/tcw_back.sv]
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELLS  = COLUMNS * (ROWS - 1),
  localparam int AW     = $clog2(CELLS),
  localparam int XW     = $clog2(COLUMNS),
  localparam int YW     = $clog2(ROWS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  tcw_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            hold,
  output logic            ram_we,
  output logic [AW-1:0]   ram_waddr,
  output logic [15:0]     ram_wdata,
  output logic [AW-1:0]   ram_raddr,
  input  logic [15:0]     ram_rdata,
  output logic            res_valid,
  input  logic            res_pop,
  output logic [6:0]      cursor_column,
  output logic [4:0]      cursor_row,
  output logic [7:0]      read_character,
  output logic [7:0]      read_color
);

  localparam int SHIFT = COLUMNS * (ROWS - 2);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_DRAIN
  } state_t;

  state_t        state;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [7:0]    pen;
  logic [1:0]    phase;
  logic [AW-1:0] kcnt;
  logic [7:0]    clr_col;
  logic          clr_res;
  logic          rd_ok;
  logic          wv;
  logic [AW-1:0] wa;
  logic          wclr;
  logic [7:0]    res_ch;
  logic [7:0]    res_col;

  logic          start;
  logic          plain;
  logic [XW:0]   x_inc;
  logic [YW-1:0] y_inc;
  logic [AW-1:0] cur_addr;
  logic          last_k;

  assign start    = (state == S_IDLE) && q_valid && !res_valid;
  assign q_pop    = start;
  assign hold     = (state == S_CLEAR) && !clr_res;
  assign x_inc    = {1'b0, x} + 1'b1;
  assign y_inc    = y + 1'b1;
  assign cur_addr = AW'(y) * AW'(COLUMNS) + AW'(x);
  assign last_k   = (kcnt == AW'(CELLS - 1));
  assign plain    = (q_item.kind != tcw_pkg::K_READ) &&
                    ((phase == 2'd0) || ((phase == 2'd1) &&
                     (q_item.kind != tcw_pkg::K_SEL_COLOR) &&
                     (q_item.kind != tcw_pkg::K_SEL_CLEAR)));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {pen, q_item.data_byte};
    ram_raddr = AW'(q_item.read_index);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = kcnt;
        ram_wdata = {clr_col, 8'h00};
      end
      S_IDLE: begin
        // selector bytes outside an escape are printable too
        ram_we = start && plain && (q_item.kind != tcw_pkg::K_NEWLINE) &&
                 (q_item.kind != tcw_pkg::K_DC1);
      end
      S_SCROLL, S_DRAIN: begin
        ram_we    = wv;
        ram_waddr = wa;
        ram_wdata = wclr ? {ram_rdata[15:8], 8'h00} : ram_rdata;
        // rows above the bottom copy from one row down
        ram_raddr = (32'(kcnt) < SHIFT) ? AW'(32'(kcnt) + COLUMNS) : kcnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      x         <= '0;
      y         <= '0;
      pen       <= tcw_pkg::PEN_RESET;
      phase     <= 2'd0;
      kcnt      <= '0;
      clr_col   <= 8'h00;
      clr_res   <= 1'b0;
      wv        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          kcnt <= kcnt + 1'b1;
          if (last_k) begin
            state <= S_IDLE;
            if (clr_res) begin
              res_valid <= 1'b1;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            res_ch  <= 8'h00;
            res_col <= 8'h00;
            if (q_item.kind == tcw_pkg::K_READ) begin
              rd_ok <= (32'(q_item.read_index) < CELLS);
              state <= S_READ;
            end else if (phase == 2'd2) begin
              pen       <= q_item.data_byte;
              phase     <= 2'd0;
              res_valid <= 1'b1;
            end else if (phase == 2'd3) begin
              pen     <= q_item.data_byte;
              clr_col <= q_item.data_byte;
              clr_res <= 1'b1;
              x       <= '0;
              y       <= '0;
              phase   <= 2'd0;
              kcnt    <= '0;
              state   <= S_CLEAR;
            end else if (!plain) begin
              phase     <= (q_item.kind == tcw_pkg::K_SEL_COLOR) ? 2'd2 : 2'd3;
              res_valid <= 1'b1;
            end else if (q_item.kind == tcw_pkg::K_DC1) begin
              phase     <= 2'd1;
              res_valid <= 1'b1;
            end else begin
              phase <= 2'd0;
              if ((q_item.kind == tcw_pkg::K_NEWLINE) || (32'(x_inc) >= COLUMNS)) begin
                x <= '0;
                if (y_inc == YW'(ROWS - 1)) begin
                  // cursor stays on the last stored row while the screen moves up
                  y     <= YW'(ROWS - 2);
                  kcnt  <= '0;
                  wv    <= 1'b0;
                  state <= S_SCROLL;
                end else begin
                  y         <= y_inc;
                  res_valid <= 1'b1;
                end
              end else begin
                x         <= XW'(x_inc);
                res_valid <= 1'b1;
              end
            end
          end
        end
        S_READ: begin
          if (rd_ok) begin
            res_ch  <= ram_rdata[7:0];
            res_col <= ram_rdata[15:8];
          end
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_SCROLL: begin
          wv   <= 1'b1;
          wa   <= kcnt;
          wclr <= (32'(kcnt) >= SHIFT);
          kcnt <= kcnt + 1'b1;
          if (last_k) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          wv        <= 1'b0;
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cursor_column  = 7'(x);
  assign cursor_row     = 5'(y);
  assign read_character = res_ch;
  assign read_color     = res_col;

`ifndef ASSERT_OFF
  a_scroll_order: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCROLL) && wv) |-> (wa < ram_raddr))
    else $error("scroll write overtakes read");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (32'(y) <= ROWS - 2))
    else $error("cursor row beyond stored rows");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (32'(x) < COLUMNS))
    else $error("cursor column beyond width");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (res_valid || (state != S_IDLE) || $past(state == S_IDLE)))
    else $error("request taken without result or work");
`endif

endmodule
